// ----- rtl/mbod_pkg.sv -----
`default_nettype none

package mbod_pkg;

    // Default sizing, handed to the top level as parameter defaults
    localparam int ADDR_BITS_DEF     = 16;
    localparam int OVERLAY_BYTES_DEF = 16384;
    localparam int NUM_OVERLAYS_DEF  = 2;

    // Fixed register file shape
    localparam int WIN_COUNT  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // RAM contents after reset
    localparam logic [7:0] RAM_RESET_BYTE = 8'hFF;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OV0_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OV0_SIZE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OV1_BASE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OV1_SIZE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OV_WRITABLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IO_MODE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IO_BASE     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IO_SIZE     = 3'd7;

    // IO hook modes; the unused code behaves as no hooks
    localparam logic [1:0] IO_NONE   = 2'd0;
    localparam logic [1:0] IO_ALL    = 2'd1;
    localparam logic [1:0] IO_WINDOW = 2'd2;

    // Source codes reported with each result
    localparam logic [1:0] SRC_RAM = 2'd0;
    localparam logic [1:0] SRC_OV0 = 2'd1;
    localparam logic [1:0] SRC_OV1 = 2'd2;
    localparam logic [1:0] SRC_IO  = 2'd3;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_RAW     = 2'd2,
        OP_PRELOAD = 2'd3
    } t_op;

    typedef struct packed {
        logic [WIN_COUNT-1:0][15:0] ov_base;
        logic [WIN_COUNT-1:0][14:0] ov_size;
        logic [1:0]                 ov_writable;
        logic [1:0]                 io_mode;
        logic [15:0]                io_base;
        logic [16:0]                io_size;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic        overlay_sel;
        logic        io_read_handled;
        logic [7:0]  io_read_data;
        logic        io_write_handled;
    } t_in;

    typedef struct packed {
        logic [7:0] rdata;
        logic [7:0] before_value;
        logic [1:0] source;
        logic       io_selected;
        logic       write_logged;
        logic       write_dropped;
    } t_out;

    // Decode result: memory strobes and how to build the result byte lanes
    typedef struct packed {
        logic       ov_we;
        logic       ram_we;
        logic       rdata_from_mem;
        logic       before_from_mem;
        logic       from_overlay;
        logic [7:0] rdata_imm;
        logic [7:0] before_imm;
        logic [1:0] source;
        logic       io_selected;
        logic       write_logged;
        logic       write_dropped;
    } t_dec;

endpackage

`default_nettype wire

// ----- rtl/mbod_decode.sv -----
`default_nettype none

module mbod_decode #(
    parameter int ADDR_BITS     = mbod_pkg::ADDR_BITS_DEF,
    parameter int OVERLAY_BYTES = mbod_pkg::OVERLAY_BYTES_DEF,
    parameter int NUM_OVERLAYS  = mbod_pkg::NUM_OVERLAYS_DEF,
    parameter int OV_AW         = $clog2(NUM_OVERLAYS * OVERLAY_BYTES)
) (
    input  wire logic                  i_valid,
    input  wire mbod_pkg::t_cfg        i_cfg,
    input  wire mbod_pkg::t_in         i_item,
    output mbod_pkg::t_dec             o_dec,
    output logic [ADDR_BITS-1:0]       o_ram_addr,
    output logic [OV_AW-1:0]           o_ov_addr
);

    localparam logic [15:0] BUS_MASK16 =
        (ADDR_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << ADDR_BITS) - 32'd1);
    localparam logic [16:0] OV_LIMIT  = 17'(OVERLAY_BYTES);
    localparam logic [18:0] OV_STRIDE = 19'(OVERLAY_BYTES);

    logic [15:0]                 a16;
    logic [23:0]                 a_ext;
    logic [mbod_pkg::WIN_COUNT-1:0] hit;
    logic [mbod_pkg::WIN_COUNT-1:0][15:0] off;
    logic [16:0]                 sz  [mbod_pkg::WIN_COUNT];
    logic [17:0]                 wend[mbod_pkg::WIN_COUNT];
    logic                        win_any;
    logic                        win_idx;
    logic [1:0]                  raw_src;
    logic [17:0]                 io_end;
    logic                        io_sel;
    logic                        pre_ok;
    logic [18:0]                 win_lin;
    logic [18:0]                 pre_lin;

    // Bus address masked to the decoded width
    assign a16        = i_item.addr & BUS_MASK16;
    assign a_ext      = {8'd0, a16};
    assign o_ram_addr = a_ext[ADDR_BITS-1:0];

    // Overlay window compares, size saturated, ends without wrap
    always_comb begin
        for (int w = 0; w < mbod_pkg::WIN_COUNT; w++) begin
            sz[w]   = ({2'b00, i_cfg.ov_size[w]} > OV_LIMIT) ? OV_LIMIT
                                                             : {2'b00, i_cfg.ov_size[w]};
            wend[w] = {2'b00, i_cfg.ov_base[w]} + {1'b0, sz[w]};
            hit[w]  = (w < NUM_OVERLAYS) && (a16 >= i_cfg.ov_base[w])
                      && ({2'b00, a16} < wend[w]);
            off[w]  = a16 - i_cfg.ov_base[w];
        end
    end

    // Higher-numbered window wins
    assign win_any = |hit;
    assign win_idx = hit[1];
    assign raw_src = !win_any ? mbod_pkg::SRC_RAM
                   : (win_idx ? mbod_pkg::SRC_OV1 : mbod_pkg::SRC_OV0);

    // IO space
    assign io_end = {2'b00, i_cfg.io_base} + {1'b0, i_cfg.io_size};
    assign io_sel = (i_cfg.io_mode == mbod_pkg::IO_ALL)
                 || ((i_cfg.io_mode == mbod_pkg::IO_WINDOW)
                     && (a16 >= i_cfg.io_base) && ({2'b00, a16} < io_end));

    // Overlay store addresses: window slot plus offset
    assign win_lin = (win_idx ? OV_STRIDE : 19'd0) + {3'd0, off[win_idx]};
    assign pre_lin = (i_item.overlay_sel ? OV_STRIDE : 19'd0) + {3'd0, i_item.addr};
    assign pre_ok  = ({1'b0, i_item.addr} < OV_LIMIT)
                  && (32'(i_item.overlay_sel) < NUM_OVERLAYS);
    assign o_ov_addr = (i_item.op == mbod_pkg::OP_PRELOAD) ? pre_lin[OV_AW-1:0]
                                                           : win_lin[OV_AW-1:0];

    // Operation decode
    always_comb begin
        o_dec              = '0;
        o_dec.from_overlay = win_any;
        case (i_item.op)
            mbod_pkg::OP_READ: begin
                o_dec.io_selected = io_sel;
                if (io_sel && i_item.io_read_handled) begin
                    o_dec.rdata_imm = i_item.io_read_data;
                    o_dec.source    = mbod_pkg::SRC_IO;
                end else begin
                    o_dec.rdata_from_mem = 1'b1;
                    o_dec.source         = raw_src;
                end
            end
            mbod_pkg::OP_RAW: begin
                o_dec.io_selected    = io_sel;
                o_dec.rdata_from_mem = 1'b1;
                o_dec.source         = raw_src;
            end
            mbod_pkg::OP_WRITE: begin
                o_dec.io_selected = io_sel;
                o_dec.rdata_imm   = i_item.wdata;
                if (io_sel && i_item.io_read_handled) begin
                    o_dec.before_imm = i_item.io_read_data;
                end else begin
                    o_dec.before_from_mem = 1'b1;
                end
                if (io_sel && i_item.io_write_handled) begin
                    o_dec.source = mbod_pkg::SRC_IO;
                end else if (win_any) begin
                    o_dec.source = raw_src;
                    if (i_cfg.ov_writable[win_idx]) begin
                        o_dec.ov_we = i_valid;
                    end else begin
                        o_dec.write_dropped = 1'b1;
                    end
                end else begin
                    o_dec.ram_we       = i_valid;
                    o_dec.write_logged = 1'b1;
                end
            end
            mbod_pkg::OP_PRELOAD: begin
                o_dec.rdata_imm = i_item.wdata;
                if (pre_ok) begin
                    o_dec.ov_we  = i_valid;
                    o_dec.source = i_item.overlay_sel ? mbod_pkg::SRC_OV1
                                                      : mbod_pkg::SRC_OV0;
                end
            end
            default: begin
                o_dec.rdata_imm = i_item.wdata;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/memory_bus_overlay_decoder.sv -----
// Byte-wide memory bus decoder with two overlay windows and an IO window.
//
// Channels: an access is transferred on i_item at a rising edge with start
// high and busy low. Its result appears on o_result for exactly one cycle
// with o_valid high, after the input register and the result register; the
// receiver cannot stall, so no result is ever held back.
// Throughput: one access per cycle, sustained while busy is low. The access
// is registered, decoded by parallel window compares, and performs one
// read-before-write of the RAM or overlay store at the next edge; the result
// lanes come from that registered read data or from the registered decode.
// Configuration: i_cfg_we, i_cfg_idx and i_cfg_wdata write one register per
// cycle, to be used only while no access is in flight.
// Reset: i_rst_n is synchronous and active low. After reset the block fills
// the RAM with 0xFF, one byte a cycle, holding busy high until the sweep
// has written the last address. Configuration writes are taken during the
// fill. Overlay store contents are undefined until preloaded or written.
`default_nettype none

module memory_bus_overlay_decoder #(
    parameter int ADDR_BITS     = mbod_pkg::ADDR_BITS_DEF,
    parameter int OVERLAY_BYTES = mbod_pkg::OVERLAY_BYTES_DEF,
    parameter int NUM_OVERLAYS  = mbod_pkg::NUM_OVERLAYS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire mbod_pkg::t_in                   i_item,
    output logic                                 o_valid,
    output mbod_pkg::t_out                       o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [mbod_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mbod_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int RAM_DEPTH = 2 ** ADDR_BITS;
    localparam int OV_DEPTH  = NUM_OVERLAYS * OVERLAY_BYTES;
    localparam int OV_AW     = $clog2(OV_DEPTH);

    mbod_pkg::t_cfg        r_cfg;
    mbod_pkg::t_in         r_s1;
    logic                  r_s1_v;
    mbod_pkg::t_dec        dec;
    mbod_pkg::t_dec        r_dec;
    logic                  r_s2_v;
    logic [ADDR_BITS-1:0]  ram_addr;
    logic [OV_AW-1:0]      ov_addr;
    logic                  r_clearing;
    logic [ADDR_BITS-1:0]  r_clr_addr;
    logic [ADDR_BITS-1:0]  n_clr_addr;
    logic [ADDR_BITS-1:0]  ram_port_addr;
    logic                  ram_port_we;
    logic [7:0]            ram_port_wdata;
    logic [7:0]            r_ram [RAM_DEPTH];
    logic [7:0]            r_ram_q;
    logic [7:0]            r_ov [OV_DEPTH];
    logic [7:0]            r_ov_q;
    logic [7:0]            mem_q;

    assign busy = r_clearing;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mbod_pkg::CFG_OV0_BASE:    r_cfg.ov_base[0]  <= i_cfg_wdata[15:0];
                mbod_pkg::CFG_OV0_SIZE:    r_cfg.ov_size[0]  <= i_cfg_wdata[14:0];
                mbod_pkg::CFG_OV1_BASE:    r_cfg.ov_base[1]  <= i_cfg_wdata[15:0];
                mbod_pkg::CFG_OV1_SIZE:    r_cfg.ov_size[1]  <= i_cfg_wdata[14:0];
                mbod_pkg::CFG_OV_WRITABLE: r_cfg.ov_writable <= i_cfg_wdata[1:0];
                mbod_pkg::CFG_IO_MODE:     r_cfg.io_mode     <= i_cfg_wdata[1:0];
                mbod_pkg::CFG_IO_BASE:     r_cfg.io_base     <= i_cfg_wdata[15:0];
                mbod_pkg::CFG_IO_SIZE:     r_cfg.io_size     <= i_cfg_wdata[16:0];
                default: begin
                end
            endcase
        end
    end

    // RAM fill sweep after reset
    assign n_clr_addr = r_clr_addr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= n_clr_addr;
            if (&r_clr_addr) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_s1 <= i_item;
        end
    end

    mbod_decode #(
        .ADDR_BITS     (ADDR_BITS),
        .OVERLAY_BYTES (OVERLAY_BYTES),
        .NUM_OVERLAYS  (NUM_OVERLAYS),
        .OV_AW         (OV_AW)
    ) u_decode (
        .i_valid    (r_s1_v),
        .i_cfg      (r_cfg),
        .i_item     (r_s1),
        .o_dec      (dec),
        .o_ram_addr (ram_addr),
        .o_ov_addr  (ov_addr)
    );

    // RAM: one port, shared by the fill sweep; old data read out on a write
    assign ram_port_addr  = r_clearing ? r_clr_addr : ram_addr;
    assign ram_port_we    = r_clearing || dec.ram_we;
    assign ram_port_wdata = r_clearing ? mbod_pkg::RAM_RESET_BYTE : r_s1.wdata;

    always_ff @(posedge i_clk) begin
        r_ram_q <= r_ram[ram_port_addr];
        if (ram_port_we) begin
            r_ram[ram_port_addr] <= ram_port_wdata;
        end
    end

    // Overlay store, same read-before-write port
    always_ff @(posedge i_clk) begin
        r_ov_q <= r_ov[ov_addr];
        if (dec.ov_we) begin
            r_ov[ov_addr] <= r_s1.wdata;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec <= dec;
    end

    // Result lanes
    assign mem_q   = r_dec.from_overlay ? r_ov_q : r_ram_q;
    assign o_valid = r_s2_v;

    always_comb begin
        o_result               = '0;
        o_result.rdata         = r_dec.rdata_from_mem ? mem_q : r_dec.rdata_imm;
        o_result.before_value  = r_dec.before_from_mem ? mem_q : r_dec.before_imm;
        o_result.source        = r_dec.source;
        o_result.io_selected   = r_dec.io_selected;
        o_result.write_logged  = r_dec.write_logged;
        o_result.write_dropped = r_dec.write_dropped;
    end

`ifndef SYNTHESIS
    // Every transfer yields its result after the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("result missing two cycles after transfer");

    // No result while the RAM fill is running
    a_no_result_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_valid)
        else $error("result during RAM fill");

    // Access writes never collide with the fill sweep
    a_fill_port_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !(dec.ram_we || dec.ov_we))
        else $error("store write during RAM fill");

    // A write is either logged to RAM or dropped, not both
    a_log_or_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_result.write_logged && o_result.write_dropped))
        else $error("write both logged and dropped");
`endif

endmodule

`default_nettype wire
